@@ sv/asd_pkg.sv @@
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the accelerometer step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

   localparam int ACCEL_W  = 16;
   localparam int SCALE_W  = 16;
   localparam int LIMIT_W  = 16;
   localparam int OFFSET_W = 18;
   localparam int PROD_W   = ACCEL_W + SCALE_W;
   localparam int LEVEL_W  = 24;
   localparam int SWING_W  = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWING_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_SCALE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_OFFSET = 2'd2;

   localparam logic [LIMIT_W-1:0]         SWING_LIMIT_RESET  = 16'd2560;
   localparam logic signed [SCALE_W-1:0]  AXIS_SCALE_RESET   = -16'sd3133;
   localparam logic [OFFSET_W-1:0]        LEVEL_OFFSET_RESET = 18'd61440;

   // floor(s/3) for signed s: bias to non-negative, multiply by ceil(2^25/3)
   localparam int DIV3_IN_W  = 25;
   localparam int DIV3_Q_W   = 24;
   localparam int DIV3_SHIFT = 25;
   localparam logic [23:0] DIV3_RECIP    = 24'hAAAAAB;
   localparam logic [25:0] DIV3_BIAS     = 26'd12582912;  // 3 * 2^22
   localparam logic [25:0] DIV3_BIAS_OUT = 26'd4194304;   // bias / 3

   typedef enum logic [1:0] {
      DIR_FLAT,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   typedef enum logic [1:0] {
      MATCH_NONE,
      MATCH_MIN,
      MATCH_MAX
   } match_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]        swing_limit;
      logic signed [SCALE_W-1:0] axis_scale;
      logic [OFFSET_W-1:0]       level_offset;
   } cfg_type;

   typedef struct packed {
      logic                      valid;
      logic signed [LEVEL_W-1:0] level;
   } level_xfer_type;

endpackage

@@ sv/asd_front.sv @@
// ----------------------------------------------------------------------------
// asd_front
// Level pipeline: scales the three axes, sums, divides by 1536 with floor
// and adds the offset. Three register stages, one sample per cycle.
// ----------------------------------------------------------------------------
module asd_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  asd_pkg::cfg_type                        cfg,
   input  logic                                    in_accept,
   input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_x,
   input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_y,
   input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_z,
   output asd_pkg::level_xfer_type                 level_out,
   output logic [1:0]                              inflight
);

   logic                                  valid0_ff, valid1_ff, valid2_ff;
   logic signed [asd_pkg::PROD_W-1:0]     prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [asd_pkg::PROD_W-1:0]     prod_x_in, prod_y_in, prod_z_in;
   logic [asd_pkg::DIV3_IN_W-1:0]         div_in_ff, div_in_in;
   logic [asd_pkg::DIV3_Q_W-1:0]          quot_ff, quot_in;
   logic [asd_pkg::PROD_W+1:0]            sum;
   logic [25:0]                           biased;
   logic [48:0]                           recip_prod;
   logic [25:0]                           level_wide;

   always_comb begin
      prod_x_in = accel_x * cfg.axis_scale;
      prod_y_in = accel_y * cfg.axis_scale;
      prod_z_in = accel_z * cfg.axis_scale;

      sum = {{2{prod_x_ff[asd_pkg::PROD_W-1]}}, prod_x_ff}
          + {{2{prod_y_ff[asd_pkg::PROD_W-1]}}, prod_y_ff}
          + {{2{prod_z_ff[asd_pkg::PROD_W-1]}}, prod_z_ff};
      // floor(sum / 512), then bias so the divide by 3 sees a positive value
      biased    = {sum[asd_pkg::PROD_W+1], sum[asd_pkg::PROD_W+1:9]} + asd_pkg::DIV3_BIAS;
      div_in_in = biased[asd_pkg::DIV3_IN_W-1:0];

      recip_prod = 49'(div_in_ff) * 49'(asd_pkg::DIV3_RECIP);
      quot_in    = recip_prod[asd_pkg::DIV3_SHIFT +: asd_pkg::DIV3_Q_W];

      level_wide = {2'b00, quot_ff} - asd_pkg::DIV3_BIAS_OUT + {8'd0, cfg.level_offset};
      level_out.valid = valid2_ff;
      level_out.level = level_wide[asd_pkg::LEVEL_W-1:0];

      inflight = 2'({1'b0, valid0_ff}) + 2'({1'b0, valid1_ff}) + 2'({1'b0, valid2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid0_ff <= in_accept;
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      div_in_ff <= div_in_in;
      quot_ff   <= quot_in;
   end

endmodule

@@ sv/asd_queue.sv @@
// ----------------------------------------------------------------------------
// asd_queue
// Small FIFO of levels between the level pipeline and the step tracker.
// ----------------------------------------------------------------------------
module asd_queue #(
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  asd_pkg::level_xfer_type               push,
   input  logic                                  pop,
   output asd_pkg::level_xfer_type               head,
   output logic [$clog2(DEPTH+1)-1:0]            count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [asd_pkg::LEVEL_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push.valid) - CNT_W'(do_pop);

      head.valid = (count_ff != '0);
      head.level = store_ff[rd_ptr_ff];
      count      = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.level;
      end
   end

endmodule

@@ sv/asd_back.sv @@
// ----------------------------------------------------------------------------
// asd_back
// Step tracker: direction, extreme capture and swing test on each level,
// with the result register toward the output channel.
// ----------------------------------------------------------------------------
module asd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  asd_pkg::cfg_type           cfg,
   input  asd_pkg::level_xfer_type    head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_step_found
);

   logic signed [asd_pkg::LEVEL_W-1:0] prev_level_ff, min_ff, max_ff;
   logic signed [asd_pkg::LEVEL_W-1:0] min_in, max_in;
   logic [asd_pkg::SWING_W-1:0]        prev_swing_ff, swing;
   asd_pkg::dir_type                   prev_dir_ff, dir;
   asd_pkg::match_type                 match_ff, match_in, opposite;
   logic                               rsp_valid_ff, step_ff;
   logic                               flip, kind_max, big, near_prev, prev_big, step;
   logic signed [asd_pkg::LEVEL_W:0]   diff;
   logic [asd_pkg::LEVEL_W:0]          diff_abs;
   logic [asd_pkg::SWING_W+1:0]        swing_x3, prev_x2, prev_x3;

   always_comb begin
      pop = head.valid && (!rsp_valid_ff || rsp_ready);

      priority if (head.level > prev_level_ff) dir = asd_pkg::DIR_UP;
      else if (head.level < prev_level_ff)     dir = asd_pkg::DIR_DOWN;
      else                                     dir = asd_pkg::DIR_FLAT;

      // flat after flat counts as a flip too
      flip = ((dir == asd_pkg::DIR_FLAT) && (prev_dir_ff == asd_pkg::DIR_FLAT))
          || ((dir == asd_pkg::DIR_UP)   && (prev_dir_ff == asd_pkg::DIR_DOWN))
          || ((dir == asd_pkg::DIR_DOWN) && (prev_dir_ff == asd_pkg::DIR_UP));
      kind_max = (dir != asd_pkg::DIR_UP);

      min_in = kind_max ? min_ff : prev_level_ff;
      max_in = kind_max ? prev_level_ff : max_ff;

      diff     = {max_in[asd_pkg::LEVEL_W-1], max_in} - {min_in[asd_pkg::LEVEL_W-1], min_in};
      diff_abs = diff[asd_pkg::LEVEL_W] ? -diff : diff;
      swing    = diff_abs[asd_pkg::SWING_W-1:0];

      swing_x3 = 26'(swing) + {1'b0, swing, 1'b0};
      prev_x2  = {1'b0, prev_swing_ff, 1'b0};
      prev_x3  = 26'(prev_swing_ff) + prev_x2;

      big       = swing > asd_pkg::SWING_W'(cfg.swing_limit);
      near_prev = swing_x3 > prev_x2;
      prev_big  = prev_x3 > 26'(swing);
      opposite  = kind_max ? asd_pkg::MATCH_MIN : asd_pkg::MATCH_MAX;
      step      = flip && big && near_prev && prev_big && (match_ff != opposite);

      match_in = match_ff;
      if (flip && big) begin
         if (step) match_in = kind_max ? asd_pkg::MATCH_MAX : asd_pkg::MATCH_MIN;
         else      match_in = asd_pkg::MATCH_NONE;
      end

      rsp_valid      = rsp_valid_ff;
      rsp_step_found = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_level_ff <= '0;
         prev_dir_ff   <= asd_pkg::DIR_FLAT;
         min_ff        <= '0;
         max_ff        <= '0;
         prev_swing_ff <= '0;
         match_ff      <= asd_pkg::MATCH_NONE;
      end else if (pop) begin
         rsp_valid_ff  <= 1'b1;
         step_ff       <= step;
         prev_level_ff <= head.level;
         prev_dir_ff   <= dir;
         match_ff      <= match_in;
         if (flip) begin
            min_ff        <= min_in;
            max_ff        <= max_in;
            prev_swing_ff <= swing;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

@@ sv/accel_step_detector_unit.sv @@
// ----------------------------------------------------------------------------
// accel_step_detector_unit
// Pedometer step detector on three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per sample (accel_x/y/z, 1/512 m/s^2 per LSB).
//   rsp_*  : one transaction per sample, step_found set when the sample
//            completes a detected step, in sample order.
//   csr_*  : register writes (0 swing_limit, 1 axis_scale, 2 level_offset),
//            always ready; write only while no sample is in flight.
// Path: each sample passes the level stages, the queue and the result register.
// Throughput: one sample per cycle while responses are taken. The level
//   pipeline (3 stages) runs free; req_ready drops only when pipeline plus
//   queue hold QUEUE_DEPTH levels; full rate needs a depth of at least 5.
// Stall: a stalled response holds in the output register; the queue keeps
//   taking levels, and requests stop once it fills.
// Reset: registers return to their defaults, the tracker state clears to
//   level 0, flat direction, no match; no transaction is pending.
// ----------------------------------------------------------------------------
module accel_step_detector_unit #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [asd_pkg::ACCEL_W-1:0]     req_accel_x,
   input  logic signed [asd_pkg::ACCEL_W-1:0]     req_accel_y,
   input  logic signed [asd_pkg::ACCEL_W-1:0]     req_accel_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_step_found,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [asd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [asd_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int USED_W = CNT_W + 2;

   asd_pkg::cfg_type          cfg_ff;
   asd_pkg::level_xfer_type   level_push, level_head;
   logic [1:0]                inflight;
   logic [CNT_W-1:0]          queue_count;
   logic [USED_W-1:0]         used;
   logic                      pop;
   logic                      req_accept;

   always_comb begin
      csr_ready  = 1'b1;
      used       = USED_W'(queue_count) + USED_W'(inflight);
      req_ready  = used < USED_W'(QUEUE_DEPTH);
      req_accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swing_limit  <= asd_pkg::SWING_LIMIT_RESET;
         cfg_ff.axis_scale   <= asd_pkg::AXIS_SCALE_RESET;
         cfg_ff.level_offset <= asd_pkg::LEVEL_OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            asd_pkg::CSR_SWING_LIMIT:  cfg_ff.swing_limit  <= csr_data[asd_pkg::LIMIT_W-1:0];
            asd_pkg::CSR_AXIS_SCALE:   cfg_ff.axis_scale   <= csr_data[asd_pkg::SCALE_W-1:0];
            asd_pkg::CSR_LEVEL_OFFSET: cfg_ff.level_offset <= csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   asd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (req_accept),
      .accel_x   (req_accel_x),
      .accel_y   (req_accel_y),
      .accel_z   (req_accel_z),
      .level_out (level_push),
      .inflight  (inflight)
   );

   asd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (level_push),
      .pop   (pop),
      .head  (level_head),
      .count (queue_count)
   );

   asd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (level_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_found (rsp_step_found)
   );

endmodule

@@ sv/asd_checker.sv @@
// ----------------------------------------------------------------------------
// asd_checker
// Port-level checks of the step detector, bound to the top level.
// ----------------------------------------------------------------------------
module asd_checker #(
   parameter int QUEUE_DEPTH = 8
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_step_found
);

   logic [7:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_found))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("response without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 8'(QUEUE_DEPTH + 1))
      else $error("more transactions outstanding than the design can hold");

endmodule

bind accel_step_detector_unit asd_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_asd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_step_found (rsp_step_found)
);

@@ sim/step_detector_checker.sv @@
// ----------------------------------------------------------------------------
// step_detector_checker
// Watches the sample, result and register channels of the step detector.
// It keeps its own copy of the peak and valley tracker, predicts step_found
// for every accepted sample and compares it with each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module step_detector_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [asd_pkg::ACCEL_W-1:0]  req_accel_x,
   input  logic signed [asd_pkg::ACCEL_W-1:0]  req_accel_y,
   input  logic signed [asd_pkg::ACCEL_W-1:0]  req_accel_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_step_found,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [asd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [asd_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  error_count,
   output int                                  outstanding,
   output int                                  sample_count,
   output int                                  step_count
);

   typedef struct {
      int   sample_no;
      logic step;
   } step_expect_type;

   step_expect_type pending_steps[$];
   step_expect_type head;

   // register shadow
   logic [asd_pkg::LIMIT_W-1:0]        limit_reg;
   logic signed [asd_pkg::SCALE_W-1:0] scale_reg;
   logic [asd_pkg::OFFSET_W-1:0]       offset_reg;

   // tracker state
   longint             prev_level;
   longint             low_mark;
   longint             high_mark;
   longint             prev_swing;
   asd_pkg::dir_type   prev_dir;
   asd_pkg::match_type last_match;

   int errors;
   int samples;
   int steps;

   function automatic logic track_sample(logic signed [asd_pkg::ACCEL_W-1:0] ax,
                                         logic signed [asd_pkg::ACCEL_W-1:0] ay,
                                         logic signed [asd_pkg::ACCEL_W-1:0] az);
      longint             total;
      longint             level;
      longint             swing;
      asd_pkg::dir_type   dir;
      logic               valley;
      logic               step;
      asd_pkg::match_type opposite;
      step  = 1'b0;
      total = longint'(offset_reg) * 1536
            + longint'(ax) * longint'(scale_reg)
            + longint'(ay) * longint'(scale_reg)
            + longint'(az) * longint'(scale_reg);
      // scaled axis sum over 1536 plus the level offset, rounded toward minus infinity
      level = total / 1536;
      if (total < 0 && total % 1536 != 0)
         level = level - 1;

      if (level > prev_level)
         dir = asd_pkg::DIR_UP;
      else if (level < prev_level)
         dir = asd_pkg::DIR_DOWN;
      else
         dir = asd_pkg::DIR_FLAT;

      // a flat run also counts as a turn, and records a peak
      if ((dir == asd_pkg::DIR_UP && prev_dir == asd_pkg::DIR_DOWN) ||
          (dir == asd_pkg::DIR_DOWN && prev_dir == asd_pkg::DIR_UP) ||
          (dir == asd_pkg::DIR_FLAT && prev_dir == asd_pkg::DIR_FLAT)) begin
         valley = (dir == asd_pkg::DIR_UP);
         if (valley)
            low_mark = prev_level;
         else
            high_mark = prev_level;
         swing = high_mark - low_mark;
         if (swing < 0)
            swing = -swing;
         if (swing > longint'(limit_reg)) begin
            if (valley)
               opposite = asd_pkg::MATCH_MAX;
            else
               opposite = asd_pkg::MATCH_MIN;
            if (3 * swing > 2 * prev_swing && 3 * prev_swing > swing &&
                last_match != opposite) begin
               step = 1'b1;
               if (valley)
                  last_match = asd_pkg::MATCH_MIN;
               else
                  last_match = asd_pkg::MATCH_MAX;
            end else begin
               last_match = asd_pkg::MATCH_NONE;
            end
         end
         prev_swing = swing;
      end
      prev_dir   = dir;
      prev_level = level;
      return step;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limit_reg  = asd_pkg::SWING_LIMIT_RESET;
         scale_reg  = asd_pkg::AXIS_SCALE_RESET;
         offset_reg = asd_pkg::LEVEL_OFFSET_RESET;
         prev_level = 0;
         low_mark   = 0;
         high_mark  = 0;
         prev_swing = 0;
         prev_dir   = asd_pkg::DIR_FLAT;
         last_match = asd_pkg::MATCH_NONE;
         pending_steps.delete();
         errors  = 0;
         samples = 0;
         steps   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               asd_pkg::CSR_SWING_LIMIT:  limit_reg  = csr_data[asd_pkg::LIMIT_W-1:0];
               asd_pkg::CSR_AXIS_SCALE:   scale_reg  = csr_data[asd_pkg::SCALE_W-1:0];
               asd_pkg::CSR_LEVEL_OFFSET: offset_reg = csr_data[asd_pkg::OFFSET_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (pending_steps.size() == 0) begin
               errors++;
               $display("%0t: result transaction with step_found=%0b, expected none",
                        $time, rsp_step_found);
            end else begin
               head = pending_steps.pop_front();
               if (rsp_step_found !== head.step) begin
                  errors++;
                  $display("%0t: sample %0d step_found expected %0b, actual %0b",
                           $time, head.sample_no, head.step, rsp_step_found);
               end
            end
            if (rsp_step_found === 1'b1)
               steps++;
         end

         if (req_valid && req_ready) begin
            head.sample_no = samples;
            head.step      = track_sample(req_accel_x, req_accel_y, req_accel_z);
            pending_steps.push_back(head);
            samples++;
         end
      end

      error_count  <= errors;
      outstanding  <= pending_steps.size();
      sample_count <= samples;
      step_count   <= steps;
   end

endmodule

@@ sim/accel_step_detector_unit_test.sv @@
// ----------------------------------------------------------------------------
// accel_step_detector_unit_test
// Drives accelerometer samples and register writes into the step detector.
// A short directed run covers the axis extremes, flat runs and a clean
// oscillation; the rest is walking-like waveforms with random amplitude,
// period and jitter under several register settings, mixed with noise.
// Both channels idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accel_step_detector_unit_test;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RANDOM_SAMPLES = 1950;
   localparam int NUM_SETTINGS   = 8;
   localparam int PHASE_SAMPLES  = RANDOM_SAMPLES / NUM_SETTINGS;
   localparam int DRAIN_SLACK    = 8;
   localparam int CYCLE_LIMIT    = 600000;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [asd_pkg::ACCEL_W-1:0] req_accel_x;
   logic signed [asd_pkg::ACCEL_W-1:0] req_accel_y;
   logic signed [asd_pkg::ACCEL_W-1:0] req_accel_z;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_step_found;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [asd_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [asd_pkg::CSR_DATA_W-1:0]     csr_data;

   int error_count;
   int outstanding;
   int sample_count;
   int step_count;
   int cycle_count = 0;

   // current register values, used to size the waveforms
   int cur_limit;
   int cur_scale;
   bit req_gaps_on;
   bit rsp_stall_on;

   accel_step_detector_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_found (rsp_step_found),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   step_detector_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_found (rsp_step_found),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .sample_count   (sample_count),
      .step_count     (step_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("accel_step_detector_unit test failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic int rand16();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic logic signed [asd_pkg::ACCEL_W-1:0] clip16(int v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return v[asd_pkg::ACCEL_W-1:0];
   endfunction

   // result side back-pressure
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap(rsp_stall_on);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_sample(int x, int y, int z);
      int gap;
      req_valid   <= 1'b1;
      req_accel_x <= clip16(x);
      req_accel_y <= clip16(y);
      req_accel_z <= clip16(z);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [asd_pkg::CSR_INDEX_W-1:0] idx,
                            logic [asd_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper data bits are set at random on the 16-bit registers
   task automatic write_settings(int limit, int scale, int offset);
      write_reg(asd_pkg::CSR_SWING_LIMIT, {2'($urandom_range(0, 3)), 16'(limit)});
      write_reg(asd_pkg::CSR_AXIS_SCALE, {2'($urandom_range(0, 3)), 16'(scale)});
      write_reg(asd_pkg::CSR_LEVEL_OFFSET, 18'(offset));
      cur_limit = limit;
      cur_scale = scale;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic run_phase(int quota);
      int     done_count, left, n, r, i, j, hp;
      int     bx, by, bz, x, y, z;
      int     nominal, target, pos, start, end_pt, noise_amp, jx;
      longint mag;
      bit     rising;
      done_count = 0;
      while (done_count < quota) begin
         left = quota - done_count;
         r = $urandom_range(0, 19);
         if (r < 2) begin
            n = $urandom_range(1, 6);
            if (n > left)
               n = left;
            repeat (n) send_sample(rand16(), rand16(), rand16());
         end else if (r == 2) begin
            n = $urandom_range(2, 5);
            if (n > left)
               n = left;
            x = rand16();
            y = rand16();
            z = rand16();
            repeat (n) send_sample(x, y, z);
         end else begin
            // walking-like triangle wave sized around the current swing limit
            n  = $urandom_range(20, 80);
            if (n > left)
               n = left;
            bx = int'($urandom_range(0, 16000)) - 8000;
            by = int'($urandom_range(0, 16000)) - 8000;
            bz = int'($urandom_range(0, 16000)) - 8000;
            mag = longint'((cur_scale < 0) ? -cur_scale : cur_scale);
            if (mag == 0) begin
               nominal = $urandom_range(100, 5000);
            end else begin
               mag = (longint'(cur_limit) * longint'($urandom_range(50, 300)) / 100 + 64)
                     * 1024 / mag;
               nominal = (mag > 30000) ? 30000 : ((mag < 4) ? 4 : int'(mag));
            end
            noise_amp = ($urandom_range(0, 1) == 1) ? nominal / 40 : 0;
            pos    = 0;
            rising = 1'($urandom_range(0, 1));
            i      = 0;
            while (i < n) begin
               hp     = $urandom_range(1, 10);
               target = nominal * int'($urandom_range(60, 150)) / 100;
               end_pt = rising ? target / 2 : -(target / 2);
               start  = pos;
               for (j = 1; j <= hp && i < n; j++) begin
                  pos = start + (end_pt - start) * j / hp;
                  jx  = (noise_amp > 0) ?
                        int'($urandom_range(0, 2 * noise_amp)) - noise_amp : 0;
                  send_sample(bx + pos + jx, by + pos / 2, bz + jx);
                  i++;
               end
               // linger at the turning point now and then
               if ($urandom_range(0, 5) == 0 && i < n) begin
                  send_sample(bx + pos, by + pos / 2, bz);
                  i++;
               end
               rising = !rising;
            end
         end
         done_count += n;
      end
   endtask

   initial begin
      int i;
      int p;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_accel_x <= '0;
      req_accel_y <= '0;
      req_accel_z <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= asd_pkg::CSR_SWING_LIMIT;
      csr_data    <= '0;
      cur_limit    = int'(asd_pkg::SWING_LIMIT_RESET);
      cur_scale    = int'(asd_pkg::AXIS_SCALE_RESET);
      req_gaps_on  = 1'b1;
      rsp_stall_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: axis extremes, flat after flat, clean oscillation
      send_sample(0, 0, 0);
      send_sample(32767, 32767, 32767);
      send_sample(-32768, -32768, -32768);
      send_sample(32767, -32768, 0);
      send_sample(-32768, 32767, -1);
      send_sample(-1, -1, -1);
      send_sample(-1, -1, -1);
      send_sample(-1, -1, -1);
      for (i = 0; i < 8; i++)
         send_sample((i % 2) ? -1000 : 1000, (i % 2) ? -1000 : 1000, (i % 2) ? -1000 : 1000);
      send_sample(1000, 1000, 1000);
      send_sample(1000, 1000, 1000);

      run_phase(PHASE_SAMPLES);
      for (p = 1; p < NUM_SETTINGS; p++) begin
         drain();
         case (p)
            1: write_settings(0, -32768, 0);
            2: write_settings(65535, 32767, 262143);
            3: write_settings($urandom_range(0, 65535), rand16(), $urandom_range(0, 262143));
            4: write_settings(2560, 0, $urandom_range(0, 262143));
            5: write_settings($urandom_range(100, 3000), int'($urandom_range(0, 12000)) - 6000,
                              $urandom_range(0, 262143));
            6: write_settings($urandom_range(0, 64), $urandom_range(1, 40), 262143);
            default: write_settings($urandom_range(0, 8000), rand16(),
                                    $urandom_range(0, 262143));
         endcase
         // one phase runs at full rate on both channels
         req_gaps_on  = (p != 2) && ($urandom_range(0, 3) != 0);
         rsp_stall_on = (p != 2) && ($urandom_range(0, 3) != 0);
         run_phase(PHASE_SAMPLES);
      end
      drain();

      $display("Covered %0d samples under %0d register settings; %0d flagged as steps.",
               sample_count, NUM_SETTINGS, step_count);
      $display("Mismatches: %0d, results still owed: %0d.", error_count, outstanding);
      if (error_count == 0 && outstanding == 0)
         $display("accel_step_detector_unit test passed");
      else
         $display("accel_step_detector_unit test failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/asd_pkg.sv
sv/asd_front.sv
sv/asd_queue.sv
sv/asd_back.sv
sv/accel_step_detector_unit.sv
sv/asd_checker.sv
sim/step_detector_checker.sv
sim/accel_step_detector_unit_test.sv
